@@ rtl/gbtd_pkg.sv @@
`timescale 1ns / 1ps
package gbtd_pkg;

  localparam int TIME_W     = 32;
  localparam int GAP_W      = 16;
  localparam int DIVIDEND_W = 18;
  localparam int DIVISOR_W  = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0]  REG_SOC     = 8'h20;
  localparam logic [7:0]  REG_CURRENT = 8'h0A;
  localparam logic [7:0]  REG_SPEED   = 8'h11;
  localparam logic [7:0]  SOC_MAX     = 8'd100;
  localparam logic [15:0] SPEED_MAX   = 16'd999;
  localparam logic [15:0] PERIOD_MAX  = 16'd5000;
  localparam logic [15:0] PERIOD_MIN  = 16'd50;
  localparam int          WHEEL_K     = 36;
  localparam int          CURRENT_K   = 5;
  localparam int          LEN_SHORT   = 3;
  localparam int          LEN_SPEED   = 4;
  localparam int          LEN_MIN     = 2;

  localparam logic [15:0] GAP_RST     = 16'd20;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [11:0] WHEEL_RST   = 12'd2200;
  localparam logic        MODE_RST    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_SUM,
    ST_DIV,
    ST_APPLY,
    ST_LINK,
    ST_EMIT
  } gbtd_state_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [GAP_W-1:0]  c;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic ge;
  } cmp_res_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
  } div_res_t;

endpackage

@@ rtl/gap_framed_bus_telemetry_decoder.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Ports                              | Payload
// in      | in  | in_tvalid in_tready in_tdata/tuser | cmd, rx_byte, now_ms
// out     | out | out_tvalid out_tready out_tdata    | link, speed, soc, current, counters
// cfg     | in  | cfg_we cfg_index cfg_wdata         | gap, timeout, wheel, speed mode
//
// One transaction at a time; in_tready is high only in the idle state.
// Each transaction ends with the link check. When a frame is open, a
// bit-serial gap check runs first; if it closes a frame, a checksum sweep over
// the frame memory follows and, for a speed frame in period mode, the divider.
// A result waits in the output register while the next transaction is taken;
// out_tready low stalls only the final step. Reset is synchronous, active low.
module gap_framed_bus_telemetry_decoder #(
  parameter int FRAME_BYTES = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // rx_byte [7:0], now_ms [39:8]
  input  logic [gbtd_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd [0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // link_up [0], speed_valid [1], speed_kmh10 [11:2], soc_pct [18:12],
  // current_a10 [29:19], frames_ok [45:30], frames_rejected [61:46], zero [63:62]
  output logic [gbtd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [gbtd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbtd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gbtd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);

  gbtd_state_t state_r, state_nxt;

  logic [15:0]       gap_r, gap_nxt, timeout_r, timeout_nxt;
  logic [11:0]       wheel_r, wheel_nxt;
  logic              mode_r, mode_nxt;
  logic [LW-1:0]     frame_len_r, frame_len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [TIME_W-1:0] last_byte_r, last_byte_nxt, last_valid_r, last_valid_nxt;
  logic [TIME_W-1:0] cur_time_r, cur_time_nxt;
  logic [15:0]       ok_cnt_r, ok_cnt_nxt, rej_cnt_r, rej_cnt_nxt;
  logic [9:0]        speed_val_r, speed_val_nxt;
  logic              speed_ok_r, speed_ok_nxt;
  logic [6:0]        charge_r, charge_nxt;
  logic [10:0]       current_r, current_nxt;
  logic              rv_r, rv_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              cmd_r, cmd_nxt;
  logic [7:0]        byte_r, byte_nxt, sum_r, sum_nxt;
  logic [7:0]        reg_r, reg_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic [LW-1:0]     rd_cnt_r, rd_cnt_nxt, rd_idx_r, rd_idx_nxt;
  logic              up_r, up_nxt, up;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [7:0]        store_mem [FRAME_BYTES];
  logic [7:0]        rd_data_r;
  logic              mem_we;
  logic [15:0]       raw;

  cmp_req_t cmp_req;
  cmp_res_t cmp_res;
  div_req_t div_req;
  div_res_t div_res;

  gbtd_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cmp_req),
    .res   (cmp_res)
  );

  gbtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[frame_len_r[AW-1:0]] <= byte_r;
    end
    rd_data_r <= store_mem[rd_cnt_r[AW-1:0]];
  end

  always_comb begin
    state_nxt      = state_r;
    gap_nxt        = gap_r;
    timeout_nxt    = timeout_r;
    wheel_nxt      = wheel_r;
    mode_nxt       = mode_r;
    frame_len_nxt  = frame_len_r;
    ovf_nxt        = ovf_r;
    last_byte_nxt  = last_byte_r;
    last_valid_nxt = last_valid_r;
    cur_time_nxt   = cur_time_r;
    ok_cnt_nxt     = ok_cnt_r;
    rej_cnt_nxt    = rej_cnt_r;
    speed_val_nxt  = speed_val_r;
    speed_ok_nxt   = speed_ok_r;
    charge_nxt     = charge_r;
    current_nxt    = current_r;
    rv_nxt         = rv_r;
    out_valid_nxt  = out_valid_r;
    cmd_nxt        = cmd_r;
    byte_nxt       = byte_r;
    sum_nxt        = sum_r;
    reg_nxt        = reg_r;
    b1_nxt         = b1_r;
    b2_nxt         = b2_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_idx_nxt     = rd_idx_r;
    up_nxt         = up_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    up             = 1'b0;
    raw            = {b1_r, b2_r};
    in_tready      = (state_r == ST_IDLE);

    cmp_req.start  = 1'b0;
    cmp_req.a      = (state_r == ST_IDLE) ? in_tdata[IN_DATA_W-1:8] : cur_time_r;
    cmp_req.b      = (state_r == ST_IDLE) ? last_byte_r : last_valid_r;
    cmp_req.c      = (state_r == ST_IDLE) ? gap_r : timeout_r;
    div_req.start    = 1'b0;
    div_req.dividend = DIVIDEND_W'(wheel_r) * DIVIDEND_W'(WHEEL_K);
    div_req.divisor  = raw;

    if (cfg_we) begin
      case (cfg_index)
        CFG_GAP:     gap_nxt = cfg_wdata;
        CFG_TIMEOUT: timeout_nxt = cfg_wdata;
        CFG_WHEEL:   wheel_nxt = cfg_wdata[11:0];
        CFG_MODE:    mode_nxt = cfg_wdata[0];
        default:     ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_tuser;
          byte_nxt     = in_tdata[7:0];
          cur_time_nxt = in_tdata[IN_DATA_W-1:8];
          if (frame_len_r != '0) begin
            cmp_req.start = 1'b1;
            state_nxt     = ST_GAP;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end
      ST_GAP: begin
        if (cmp_res.done) begin
          if (!cmp_res.ge) begin
            state_nxt = ST_APPLY;
          end else if (ovf_r || frame_len_r < LW'(LEN_MIN)) begin
            rej_cnt_nxt   = rej_cnt_r + 16'd1;
            frame_len_nxt = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = ST_APPLY;
          end else begin
            rd_cnt_nxt = '0;
            rv_nxt     = 1'b0;
            sum_nxt    = '0;
            state_nxt  = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (rd_cnt_r != frame_len_r) begin
          rd_cnt_nxt = rd_cnt_r + LW'(1);
          rd_idx_nxt = rd_cnt_r;
          rv_nxt     = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          if (rd_idx_r == LW'(0)) reg_nxt = rd_data_r;
          if (rd_idx_r == LW'(1)) b1_nxt = rd_data_r;
          if (rd_idx_r == LW'(2)) b2_nxt = rd_data_r;
          if (rd_idx_r == frame_len_r - LW'(1)) begin
            rv_nxt        = 1'b0;
            frame_len_nxt = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = ST_APPLY;
            if (sum_r == rd_data_r) begin
              ok_cnt_nxt     = ok_cnt_r + 16'd1;
              last_valid_nxt = cur_time_r;
              if (reg_r == REG_SOC) begin
                if (frame_len_r == LW'(LEN_SHORT) && b1_r <= SOC_MAX) begin
                  charge_nxt = b1_r[6:0];
                end
              end else if (reg_r == REG_CURRENT) begin
                if (frame_len_r == LW'(LEN_SHORT)) begin
                  current_nxt = 11'(b1_r * CURRENT_K);
                end
              end else if (reg_r == REG_SPEED) begin
                if (frame_len_r == LW'(LEN_SPEED)) begin
                  if (mode_r == 1'b0) begin
                    if (raw > SPEED_MAX) begin
                      speed_ok_nxt = 1'b0;
                    end else begin
                      speed_val_nxt = raw[9:0];
                      speed_ok_nxt  = 1'b1;
                    end
                  end else if (raw == 16'd0) begin
                    speed_ok_nxt = 1'b0;
                  end else if (raw >= PERIOD_MAX) begin
                    speed_val_nxt = '0;
                    speed_ok_nxt  = 1'b1;
                  end else if (raw < PERIOD_MIN) begin
                    speed_ok_nxt = 1'b0;
                  end else begin
                    div_req.start = 1'b1;
                    state_nxt     = ST_DIV;
                  end
                end
              end
            end else begin
              rej_cnt_nxt = rej_cnt_r + 16'd1;
            end
          end else begin
            sum_nxt = sum_r + rd_data_r;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (div_res.quot > DIVIDEND_W'(SPEED_MAX)) begin
            speed_ok_nxt = 1'b0;
          end else begin
            speed_val_nxt = div_res.quot[9:0];
            speed_ok_nxt  = 1'b1;
          end
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (cmd_r == CMD_BYTE) begin
          if (frame_len_r < LW'(FRAME_BYTES)) begin
            mem_we        = 1'b1;
            frame_len_nxt = frame_len_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          last_byte_nxt = cur_time_r;
        end
        cmp_req.start = 1'b1;
        state_nxt     = ST_LINK;
      end
      ST_LINK: begin
        if (cmp_res.done) begin
          up     = (ok_cnt_r != 16'd0) && !cmp_res.ge;
          up_nxt = up;
          if (cmd_r == CMD_TICK && !up) begin
            speed_ok_nxt = 1'b0;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, rej_cnt_r, ok_cnt_r, current_r, charge_r,
                           speed_ok_r ? speed_val_r : 10'd0,
                           speed_ok_r && up_r, up_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      gap_r        <= GAP_RST;
      timeout_r    <= TIMEOUT_RST;
      wheel_r      <= WHEEL_RST;
      mode_r       <= MODE_RST;
      frame_len_r  <= '0;
      ovf_r        <= 1'b0;
      last_byte_r  <= '0;
      last_valid_r <= '0;
      cur_time_r   <= '0;
      ok_cnt_r     <= '0;
      rej_cnt_r    <= '0;
      speed_val_r  <= '0;
      speed_ok_r   <= 1'b0;
      charge_r     <= '0;
      current_r    <= '0;
      rv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      gap_r        <= gap_nxt;
      timeout_r    <= timeout_nxt;
      wheel_r      <= wheel_nxt;
      mode_r       <= mode_nxt;
      frame_len_r  <= frame_len_nxt;
      ovf_r        <= ovf_nxt;
      last_byte_r  <= last_byte_nxt;
      last_valid_r <= last_valid_nxt;
      cur_time_r   <= cur_time_nxt;
      ok_cnt_r     <= ok_cnt_nxt;
      rej_cnt_r    <= rej_cnt_nxt;
      speed_val_r  <= speed_val_nxt;
      speed_ok_r   <= speed_ok_nxt;
      charge_r     <= charge_nxt;
      current_r    <= current_nxt;
      rv_r         <= rv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    byte_r     <= byte_nxt;
    sum_r      <= sum_nxt;
    reg_r      <= reg_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    up_r       <= up_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/gbtd_cmp.sv @@
`timescale 1ns / 1ps
module gbtd_cmp (
  input  logic               clk,
  input  logic               rst_n,
  input  gbtd_pkg::cmp_req_t req,
  output gbtd_pkg::cmp_res_t res
);
  import gbtd_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic [TIME_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [GAP_W-1:0]  c_r, c_nxt;
  logic              borrow_r, borrow_nxt, ge_r, ge_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              dbit, bout;

  // a - b, one bit per cycle from the lsb, compared against c as it goes
  always_comb begin
    dbit       = a_r[0] ^ b_r[0] ^ borrow_r;
    bout       = (~a_r[0] & b_r[0]) | (~(a_r[0] ^ b_r[0]) & borrow_r);
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    borrow_nxt = borrow_r;
    ge_nxt     = ge_r;
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      a_nxt      = req.a;
      b_nxt      = req.b;
      c_nxt      = req.c;
      borrow_nxt = 1'b0;
      ge_nxt     = 1'b1;
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
    end else if (busy_r) begin
      a_nxt      = a_r >> 1;
      b_nxt      = b_r >> 1;
      c_nxt      = c_r >> 1;
      borrow_nxt = bout;
      ge_nxt     = (dbit != c_r[0]) ? dbit : ge_r;
      cnt_nxt    = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    borrow_r <= borrow_nxt;
    ge_r     <= ge_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign res.done = done_r;
  assign res.ge   = ge_r;

endmodule

@@ rtl/gbtd_div.sv @@
`timescale 1ns / 1ps
module gbtd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gbtd_pkg::div_req_t req,
  output gbtd_pkg::div_res_t res
);
  import gbtd_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [DIVIDEND_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt, done_r, done_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quot_r[DIVIDEND_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs_r};
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quot_nxt = req.dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[DIVISOR_W+1]) begin
        rem_nxt = shifted[DIVISOR_W-1:0];
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
      quot_nxt = {quot_r[DIVIDEND_W-2:0], ~trial[DIVISOR_W+1]};
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule
